@@ rtl/ccl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ccl_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int GRAY_BITS      = 8;
  localparam int SLOTS          = 4;   // most links one transaction can release
  localparam int SLOT_W         = 2;
  localparam int QDEPTH         = 4;   // bundles held between front and back
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_JOINED = 2'd0,
    REG_TAIL_JOINED = 2'd1
  } cfg_reg_t;

  // Control word of one bundle of released links.
  typedef struct packed {
    logic [SLOT_W-1:0] cnt_m1;  // links in bundle minus one
    logic              last;    // final link of bundle closes the chain
  } bctl_t;

endpackage
`default_nettype wire

@@ rtl/ccl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccl_front #(
  parameter int COORD_BITS = ccl_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [ccl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ccl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] in_link,
  input  wire logic                                  in_end,
  input  wire logic                                  q_full,
  output logic                                       push,
  output logic [ccl_pkg::SLOTS-1:0][2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] push_links,
  output ccl_pkg::bctl_t                             push_ctl
);

  localparam int LW = 2*COORD_BITS + ccl_pkg::GRAY_BITS;
  localparam int SW = ccl_pkg::SLOT_W;

  logic          head_joined;
  logic          tail_joined;
  logic [LW-1:0] w [3];
  logic [1:0]    fill;
  logic [1:0]    seen;

  logic [LW-1:0] a [4];
  logic [LW-1:0] p [4];
  logic [LW-1:0] f [4];
  logic [LW-1:0] w_next [3];
  logic [1:0]    fill_next;
  logic [1:0]    seen_next;
  logic [SW-1:0] pc;
  logic [SW-1:0] slot_j;
  logic [2:0]    total;
  logic          accept;

  function automatic logic [COORD_BITS-1:0] lx(input logic [LW-1:0] v);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] ly(input logic [LW-1:0] v);
    return v[2*COORD_BITS-1:COORD_BITS];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_joined <= 1'b0;
      tail_joined <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccl_pkg::REG_HEAD_JOINED: head_joined <= cfg_data[0];
        ccl_pkg::REG_TAIL_JOINED: tail_joined <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // window as it stands with the new link appended
    for (int i = 0; i < 3; i++) begin
      a[i] = (fill > 2'(i)) ? w[i] : in_link;
    end
    a[3] = in_link;

    for (int i = 0; i < 4; i++) begin
      p[i] = '0;
      f[i] = '0;
    end
    pc        = '0;
    w_next[0] = a[0];
    w_next[1] = a[1];
    w_next[2] = a[2];
    fill_next = fill + 2'd1;
    seen_next = seen;

    if (seen == 2'd2) begin
      seen_next = 2'd3;
      if (!head_joined &&
          ((lx(a[0]) == lx(a[1]) && ly(a[0]) == ly(a[2])) ||
           (ly(a[0]) == ly(a[1]) && lx(a[0]) == lx(a[2])))) begin
        p[0]      = a[1];
        p[1]      = a[0];
        pc        = SW'(2);
        w_next[0] = a[2];
        fill_next = 2'd1;
      end
    end else if (seen != 2'd3) begin
      seen_next = seen + 2'd1;
    end else if (fill == 2'd3) begin
      // staircase test on the full four-link window
      if ((lx(a[0]) < lx(a[1]) && ly(a[0]) > ly(a[1]) && ly(a[1]) == ly(a[2]) &&
           lx(a[1]) > lx(a[2]) && lx(a[2]) < lx(a[3]) && ly(a[2]) > ly(a[3])) ||
          (lx(a[0]) > lx(a[1]) && ly(a[0]) < ly(a[1]) && ly(a[1]) == ly(a[2]) &&
           lx(a[1]) < lx(a[2]) && lx(a[2]) > lx(a[3]) && ly(a[2]) < ly(a[3]))) begin
        p[0]      = a[0];
        p[1]      = a[2];
        p[2]      = a[1];
        pc        = SW'(3);
        w_next[0] = a[3];
        fill_next = 2'd1;
      end else begin
        p[0]      = a[0];
        pc        = SW'(1);
        w_next[0] = a[1];
        w_next[1] = a[2];
        w_next[2] = a[3];
        fill_next = 2'd3;
      end
    end

    // tail flush
    f[0] = w_next[0];
    f[1] = w_next[1];
    f[2] = w_next[2];
    if (fill_next == 2'd3 && !tail_joined &&
        ((lx(w_next[2]) == lx(w_next[1]) && ly(w_next[0]) == ly(w_next[2])) ||
         (ly(w_next[2]) == ly(w_next[1]) && lx(w_next[0]) == lx(w_next[2])))) begin
      f[1] = w_next[2];
      f[2] = w_next[1];
    end

    total = {1'b0, pc} + (in_end ? {1'b0, fill_next} : 3'd0);

    for (int k = 0; k < ccl_pkg::SLOTS; k++) begin
      slot_j = SW'(k) - pc;
      if ((SW+1)'(k) < {1'b0, pc}) begin
        push_links[k] = p[k];
      end else begin
        push_links[k] = f[slot_j];
      end
    end
    push_ctl.cnt_m1 = SW'(total - 3'd1);
    push_ctl.last   = in_end;
    push            = accept && (total != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      seen <= '0;
    end else if (accept) begin
      fill <= in_end ? 2'd0 : fill_next;
      seen <= in_end ? 2'd0 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w[0] <= w_next[0];
      w[1] <= w_next[1];
      w[2] <= w_next[2];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ccl_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccl_queue #(
  parameter int COORD_BITS = ccl_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  input  wire logic [ccl_pkg::SLOTS-1:0][2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] push_links,
  input  wire ccl_pkg::bctl_t                        push_ctl,
  output logic                                       full,
  input  wire logic                                  pop,
  output logic                                       empty,
  output logic [ccl_pkg::SLOTS-1:0][2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] head_links,
  output ccl_pkg::bctl_t                             head_ctl
);

  localparam int LW    = 2*COORD_BITS + ccl_pkg::GRAY_BITS;
  localparam int PTR_W = $clog2(ccl_pkg::QDEPTH);
  localparam int CNT_W = $clog2(ccl_pkg::QDEPTH + 1);

  logic [ccl_pkg::SLOTS-1:0][LW-1:0] links_q [ccl_pkg::QDEPTH];
  ccl_pkg::bctl_t                    ctl_q   [ccl_pkg::QDEPTH];
  logic [PTR_W-1:0]                  wr_ptr;
  logic [PTR_W-1:0]                  rd_ptr;
  logic [CNT_W-1:0]                  count;

  assign full       = (count == CNT_W'(ccl_pkg::QDEPTH));
  assign empty      = (count == '0);
  assign head_links = links_q[rd_ptr];
  assign head_ctl   = ctl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      links_q[wr_ptr] <= push_links;
      ctl_q[wr_ptr]   <= push_ctl;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ccl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccl_back #(
  parameter int COORD_BITS = ccl_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  input  wire logic [ccl_pkg::SLOTS-1:0][2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] q_links,
  input  wire ccl_pkg::bctl_t                        q_ctl,
  output logic                                       pop,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [2*COORD_BITS+ccl_pkg::GRAY_BITS-1:0] out_link,
  output logic                                       out_last
);

  localparam int LW = 2*COORD_BITS + ccl_pkg::GRAY_BITS;
  localparam int SW = ccl_pkg::SLOT_W;

  logic                              busy;
  logic [SW-1:0]                     idx;
  logic [ccl_pkg::SLOTS-1:0][LW-1:0] links;
  ccl_pkg::bctl_t                    ctl;
  logic                              last_slot;
  logic                              take;
  logic                              load;

  assign last_slot = (idx == ctl.cnt_m1);
  assign take      = busy && out_ready;
  assign load      = !busy || (take && last_slot);
  assign pop       = load && !q_empty;

  assign out_valid = busy;
  assign out_link  = links[idx];
  assign out_last  = ctl.last && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= !q_empty;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      links <= q_links;
      ctl   <= q_ctl;
    end
  end

endmodule
`default_nettype wire

@@ rtl/contour_chain_link_reorder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Signals                         Contents
// s_*       in   s_tvalid s_tready s_tdata s_tlast   one chain link, tlast = final link
// m_*       out  m_tvalid m_tready m_tdata m_tlast   one reordered link, tlast = chain end
// cfg_*     in   cfg_we cfg_index cfg_data          0: head_joined, 1: tail_joined
//
// Input side takes one link per cycle while the bundle queue has room. Each
// input transaction releases a bundle of 0..4 links into a 4-deep queue; the
// output stage unpacks each bundle, sending one link per cycle while m_tready is high.
// From input to output a link passes the queue entry, then the output register.
// Reset (rst, synchronous) clears window fill, chain position, registers, queue.
// Either side can stall independently; the queue absorbs bursts of long bundles.
module contour_chain_link_reorder_unit #(
  parameter int COORD_BITS = ccl_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // link_x, link_y, link_gray from bit 0 up, zero padded to bytes
  input  wire logic [((2*COORD_BITS+ccl_pkg::GRAY_BITS+7)/8)*8-1:0] s_tdata,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_x, out_y, out_gray from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+ccl_pkg::GRAY_BITS+7)/8)*8-1:0] m_tdata,
  output logic                                m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LW   = 2*COORD_BITS + ccl_pkg::GRAY_BITS;
  localparam int TD_W = ((LW + 7) / 8) * 8;

  logic                              q_full;
  logic                              q_empty;
  logic                              push;
  logic                              pop;
  logic [ccl_pkg::SLOTS-1:0][LW-1:0] push_links;
  logic [ccl_pkg::SLOTS-1:0][LW-1:0] head_links;
  ccl_pkg::bctl_t                    push_ctl;
  ccl_pkg::bctl_t                    head_ctl;
  logic [LW-1:0]                     out_link;

  // front: window, head/middle/tail tests, bundle build
  ccl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_link    (s_tdata[LW-1:0]),
    .in_end     (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_links (push_links),
    .push_ctl   (push_ctl)
  );

  ccl_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_links (push_links),
    .push_ctl   (push_ctl),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head_links (head_links),
    .head_ctl   (head_ctl)
  );

  // back: unpacks bundles into single-link transactions
  ccl_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_links   (head_links),
    .q_ctl     (head_ctl),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_link  (out_link),
    .out_last  (m_tlast)
  );

  assign m_tdata = TD_W'(out_link);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  // tdata carries x, y, gray from bit 0 up; 2*12+8 bits fill whole bytes here
  localparam int COORD_W      = ccl_pkg::COORD_BITS_DEF;
  localparam int GRAY_W       = ccl_pkg::GRAY_BITS;
  localparam int IDX_W        = ccl_pkg::CFG_IDX_W;
  localparam int DATA_W       = ((2*COORD_W+GRAY_W+7)/8)*8;
  localparam int DRAIN_CYCLES = 6;     // path through queue and output register plus margin
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction anywhere
  localparam int RANDOM_LINKS = 345;
  localparam int CALM_LINKS   = 60;    // tail of the run, no idling on either side

  // Indexes past the two registers; the block must ignore writes to them.
  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Same bit layout as tdata: x lowest, gray highest.
  typedef struct packed {
    logic [GRAY_W-1:0]  gray;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } chain_link_t;

  // A link plus its tlast flag (chain_end on input, out_last on output).
  typedef struct packed {
    chain_link_t lk;
    logic        last;
  } flagged_link_t;

  typedef enum {ROW_LINK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    int                 x;
    int                 y;
    int                 gray;
    int                 fin;
    int                 echo;     // one-link chain: expect the link back, tlast set
    logic [IDX_W-1:0]   reg_idx;
    int                 reg_val;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [DATA_W-1:0]              s_tdata = '0;     // link_x, link_y, link_gray
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [DATA_W-1:0]              m_tdata;          // out_x, out_y, out_gray
  logic                           m_tlast;
  logic                           cfg_we = 1'b0;
  logic [IDX_W-1:0]               cfg_index = ccl_pkg::REG_HEAD_JOINED;
  logic [ccl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_echo = 1'b0;    // rides along with the input transaction

  bit idle_on = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int links_in = 0, links_out = 0, chains_in = 0, reg_writes = 0;
  int head_swaps = 0, stair_swaps = 0, tail_swaps = 0;

  // Predictor state: window of pending links, its fill, position in chain.
  chain_link_t   win [4];
  int unsigned   win_fill = 0;
  int unsigned   chain_pos = 0;
  bit            head_joined_q = 1'b0;
  bit            tail_joined_q = 1'b0;
  flagged_link_t released_links[$];   // links freed by the last input transaction
  flagged_link_t expected_links[$];   // links still owed by the block
  flagged_link_t chain_buf[$];        // random chain being sent

  chain_link_t   arrived, observed;
  flagged_link_t want;

  logic [IDX_W-1:0] reg_codes [4] = '{ccl_pkg::REG_HEAD_JOINED, ccl_pkg::REG_TAIL_JOINED,
                                      REG_SPARE_2, REG_SPARE_3};

  // Directed part. Rows marked echo carry their result in the row itself.
  stim_row_t directed_rows [32] = '{
    // one-link chains at both extremes
    '{ROW_LINK, 4095, 4095, 255, 1, 1, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    0,    0,   0, 1, 1, ccl_pkg::REG_HEAD_JOINED, 0},
    // two-link chain, passes unchanged
    '{ROW_LINK,    5,    7,   1, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    9,    3, 254, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // head corner: first two swap
    '{ROW_LINK,   10,   10,  10, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,   10,   11,  11, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,   11,   10,  12, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // falling staircase, then jump leaves cursor too near the end for a tail swap
    '{ROW_LINK,  100,   12,  20, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  102,   10,  21, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  101,   10,  22, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  103,    8,  23, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  104,    7,  24, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // rising staircase
    '{ROW_LINK,  203,    0,  30, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  201,    2,  31, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  202,    2,  32, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  200,    4,  33, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,  199,    5,  34, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // tail corner: last two swap
    '{ROW_LINK, 4095,    9,  40, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    5,    5,  41, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    5,    9,  42, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // both ends joined: same chains, no swaps
    '{ROW_REG,     0,    0,   0, 0, 0, ccl_pkg::REG_HEAD_JOINED, 1},
    '{ROW_REG,     0,    0,   0, 0, 0, ccl_pkg::REG_TAIL_JOINED, 1},
    '{ROW_LINK,   10,   10,  50, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,   10,   11,  51, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,   11,   10,  52, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK, 4095,    9,  60, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    5,    5,  61, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_LINK,    5,    9,  62, 1, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    // writes past the last register go nowhere
    '{ROW_REG,     0,    0,   0, 0, 0, REG_SPARE_2,              1},
    '{ROW_REG,     0,    0,   0, 0, 0, REG_SPARE_3,              0},
    '{ROW_REG,     0,    0,   0, 0, 0, ccl_pkg::REG_HEAD_JOINED, 0},
    '{ROW_REG,     0,    0,   0, 0, 0, ccl_pkg::REG_TAIL_JOINED, 0}
  };

  contour_chain_link_reorder_unit #(
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit staircase_at(chain_link_t a, chain_link_t b, chain_link_t c,
                                      chain_link_t d);
    bit down, up;
    down = a.x < b.x && a.y > b.y && b.y == c.y && b.x > c.x && c.x < d.x && c.y > d.y;
    up   = a.x > b.x && a.y < b.y && b.y == c.y && b.x < c.x && c.x > d.x && c.y < d.y;
    return down || up;
  endfunction

  // Advance the window by one link and collect the links it frees.
  // Tests look at links as they arrived; a swapped link leaves the window.
  function void reorder_link(chain_link_t lk, bit fin);
    chain_link_t t;
    released_links.delete();
    if (win_fill > 3) win_fill = 3;
    win[2'(win_fill)] = lk;
    win_fill++;

    if (chain_pos == 2) begin
      // third link: head corner check, unless the head is joined
      if (!head_joined_q &&
          ((win[0].x == win[1].x && win[0].y == win[2].y) ||
           (win[0].y == win[1].y && win[0].x == win[2].x))) begin
        released_links.push_back({win[1], 1'b0});
        released_links.push_back({win[0], 1'b0});
        win[0] = win[2];
        win_fill = 1;
        head_swaps++;
      end
      chain_pos = 3;
    end else if (chain_pos < 3) begin
      chain_pos++;
    end else if (win_fill == 4) begin
      if (staircase_at(win[0], win[1], win[2], win[3])) begin
        // swap the middle pair and jump three
        released_links.push_back({win[0], 1'b0});
        released_links.push_back({win[2], 1'b0});
        released_links.push_back({win[1], 1'b0});
        win[0] = win[3];
        win_fill = 1;
        stair_swaps++;
      end else begin
        released_links.push_back({win[0], 1'b0});
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win_fill = 3;
      end
    end

    if (fin) begin
      // tail corner only when the cursor sits exactly three from the end
      if (win_fill == 3 && !tail_joined_q &&
          ((win[2].x == win[1].x && win[0].y == win[2].y) ||
           (win[2].y == win[1].y && win[0].x == win[2].x))) begin
        t = win[1];
        win[1] = win[2];
        win[2] = t;
        tail_swaps++;
      end
      for (int j = 0; j < win_fill; j++)
        released_links.push_back({win[j], 1'(j + 1 == win_fill)});
      win_fill = 0;
      chain_pos = 0;
    end
  endfunction

  // Random chain. Most are 8-neighbor walks with staircases planted in them,
  // so corners and jumps happen often; the rest are tight clusters, scattered
  // noise and one- or two-link chains.
  function void build_chain;
    int unsigned style, len, cx, cy, bx, by;
    int          dx, dy;
    bit          rising;
    chain_link_t lk;
    chain_buf.delete();
    style = $urandom_range(0, 9);
    len = (style == 9) ? $urandom_range(1, 2) : $urandom_range(3, 14);
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    while (chain_buf.size() < len) begin
      if (style <= 5 && $urandom_range(0, 3) == 0 && chain_buf.size() + 4 <= len) begin
        bx = $urandom_range(0, 4092);
        by = $urandom_range(2, 4091);
        rising = 1'($urandom_range(0, 1));
        for (int k = 0; k < 4; k++) begin
          lk.gray = GRAY_W'($urandom_range(0, 255));
          if (rising) begin
            lk.x = COORD_W'(bx + ((k == 0) ? 3 : (k == 1) ? 1 : (k == 2) ? 2 : 0));
            lk.y = COORD_W'(by + ((k == 0) ? 0 : (k == 3) ? 4 : 2));
          end else begin
            lk.x = COORD_W'(bx + ((k == 0) ? 0 : (k == 1) ? 2 : (k == 2) ? 1 : 3));
            lk.y = COORD_W'(by + ((k == 0) ? 2 : (k == 3) ? -2 : 0));
          end
          chain_buf.push_back({lk, 1'b0});
        end
        cx = 32'(lk.x);
        cy = 32'(lk.y);
      end else begin
        lk.gray = GRAY_W'($urandom_range(0, 255));
        if (style == 6 || style == 7) begin
          lk.x = COORD_W'($urandom_range(0, 3));
          lk.y = COORD_W'($urandom_range(0, 3));
        end else if (style == 8) begin
          lk.x = COORD_W'($urandom_range(0, 4095));
          lk.y = COORD_W'($urandom_range(0, 4095));
        end else begin
          dx = int'($urandom_range(0, 2)) - 1;
          dy = int'($urandom_range(0, 2)) - 1;
          if (dx == 0 && dy == 0) dx = 1;
          cx = (cx + dx) & 12'hFFF;
          cy = (cy + dy) & 12'hFFF;
          lk.x = COORD_W'(cx);
          lk.y = COORD_W'(cy);
        end
        chain_buf.push_back({lk, 1'b0});
      end
    end
    chain_buf[chain_buf.size()-1].last = 1'b1;
  endfunction

  // Offer one link and hold it until the input transaction completes.
  task automatic send_link(chain_link_t lk, bit fin, bit echo);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= lk;
    s_tlast  <= fin;
    s_echo   <= echo;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold off input until every owed link is out, then let the pipe settle
  // (a link that frees nothing may still be inside).
  task automatic drain_block;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_links.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, bit val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output side back-pressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Prediction and checking in one process, so a link is always predicted
  // before its result can show up. Register writes land before any link
  // transaction of the same edge.
  always @(posedge clk) begin
    if (rst) begin
      win_fill = 0;
      chain_pos = 0;
      head_joined_q = 1'b0;
      tail_joined_q = 1'b0;
      expected_links.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ccl_pkg::REG_HEAD_JOINED: head_joined_q = cfg_data[0];
          ccl_pkg::REG_TAIL_JOINED: tail_joined_q = cfg_data[0];
          default: ;
        endcase
        reg_writes++;
      end

      if (s_tvalid && s_tready) begin
        arrived = chain_link_t'(s_tdata[$bits(chain_link_t)-1:0]);
        reorder_link(arrived, s_tlast);
        if (s_echo)
          expected_links.push_back({arrived, 1'b1});
        else
          foreach (released_links[i]) expected_links.push_back(released_links[i]);
        links_in++;
        if (s_tlast) chains_in++;
      end

      if (m_tvalid && m_tready) begin
        observed = chain_link_t'(m_tdata[$bits(chain_link_t)-1:0]);
        links_out++;
        if (expected_links.size() == 0) begin
          $error("m_tdata: unexpected transaction, x %0d y %0d gray %0d last %0d",
                 observed.x, observed.y, observed.gray, m_tlast);
          errors++;
        end else begin
          want = expected_links.pop_front();
          if (observed.x !== want.lk.x) begin
            $error("out_x: expected %0d, got %0d", want.lk.x, observed.x);
            errors++;
          end
          if (observed.y !== want.lk.y) begin
            $error("out_y: expected %0d, got %0d", want.lk.y, observed.y);
            errors++;
          end
          if (observed.gray !== want.lk.gray) begin
            $error("out_gray: expected %0d, got %0d", want.lk.gray, observed.gray);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long with no transaction on any port means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    chain_link_t lk;
    int          random_sent;
    int          split;
    random_sent = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_idx, row.reg_val != 0);
      end else begin
        lk.x = COORD_W'(row.x);
        lk.y = COORD_W'(row.y);
        lk.gray = GRAY_W'(row.gray);
        send_link(lk, row.fin != 0, row.echo != 0);
      end
    end

    // Random chains. Now and then a register changes between chains or,
    // with the block drained, in the middle of one: head_joined counts only
    // as of the third link and tail_joined as of the last.
    while (random_sent < RANDOM_LINKS) begin
      idle_on = (RANDOM_LINKS - random_sent > CALM_LINKS) && ($urandom_range(0, 3) != 0);
      build_chain();
      split = (chain_buf.size() > 1 && $urandom_range(0, 6) == 0) ?
              $urandom_range(1, chain_buf.size() - 1) : 0;
      foreach (chain_buf[i]) begin
        if (split != 0 && i == split)
          write_reg(reg_codes[2'($urandom_range(0, 3))], 1'($urandom_range(0, 1)));
        send_link(chain_buf[i].lk, chain_buf[i].last, 1'b0);
        random_sent++;
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(reg_codes[2'($urandom_range(0, 3))], 1'($urandom_range(0, 1)));
    end

    drain_block();
    $display("testbench: %0d links in %0d chains, %0d links out, %0d register writes",
             links_in, chains_in, links_out, reg_writes);
    $display("testbench: head swaps %0d, staircase swaps %0d, tail swaps %0d",
             head_swaps, stair_swaps, tail_swaps);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
